// File: rtl/core/one_shot_tick_timer_bank_unit_macros.svh
// Assertion macros used by the checker of the timer bank.
`ifndef ONE_SHOT_TICK_TIMER_BANK_UNIT_MACROS_SVH
`define ONE_SHOT_TICK_TIMER_BANK_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define OSTT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define OSTT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/ostt_pkg.sv
// Package with the item types, command codes and pipeline control type of the timer bank.
package ostt_pkg;

    localparam int CMD_W     = 2;
    localparam int ID_W      = 4;
    localparam int TICKS_W   = 16;
    localparam int CNT_OUT_W = 5;
    localparam int MASK_W    = 16;
    localparam int ID_SLOTS  = 16;

    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UNSET = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [ID_W-1:0]    timer_id;
        logic [TICKS_W-1:0] ticks;
    } req_t;

    typedef struct packed {
        logic [CNT_OUT_W-1:0] count;
        logic [MASK_W-1:0]    expired_mask;
    } rsp_t;

    typedef struct packed {
        logic adv;
        logic fire;
    } exec_ctrl_t;

endpackage

// File: rtl/core/one_shot_tick_timer_bank_unit.sv
// Top level of the one-shot tick timer bank: handshake, input register and pipeline control.
//
// Usage: each item on the req channel is one command: tick all slots, set (arm) a slot with
// a target tick count, or unset a slot. Every item produces exactly one result item on the
// rsp channel: on a tick, the number of expired slots and their mask; on an unset, 1 if the
// slot was active; on a set or an unknown command, zeros.
// An item is taken when req_valid is high and req_stall is low; a result is taken when
// rsp_valid is high and rsp_stall is low.
// An accepted item passes through the input register, then the execute register, which takes
// the slot update, and then the result register, which holds the count of expired slots;
// rsp_valid rises when the result register is loaded.
// Throughput is one item per cycle when not stalled; all slots update in parallel.
// While rsp_stall holds a waiting result, the pipeline freezes; one more item can still
// be taken into the empty input register before req_stall rises.
// Reset clears all slots to inactive with zero counts and empties the pipeline.
module one_shot_tick_timer_bank_unit #(
    parameter int SLOTS       = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  ostt_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output ostt_pkg::rsp_t rsp
);

    logic                 adv;
    logic                 accept;
    logic                 v_in_reg;
    logic                 v_in_next;
    logic                 v_ex_reg;
    logic                 v_ex_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    ostt_pkg::req_t       req_reg;
    ostt_pkg::exec_ctrl_t ctrl;
    logic [SLOTS-1:0]     expire;
    logic                 hit;

    // All stages move together whenever the result register is free or being drained.
    assign adv       = !rsp_valid_reg || !rsp_stall;
    assign req_stall = v_in_reg && !adv;
    assign accept    = req_valid && !req_stall;

    assign v_in_next      = accept || (v_in_reg && !adv);
    assign v_ex_next      = adv ? v_in_reg : v_ex_reg;
    assign rsp_valid_next = adv ? v_ex_reg : rsp_valid_reg;

    assign ctrl.adv  = adv;
    assign ctrl.fire = adv && v_in_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_in_reg      <= 1'b0;
            v_ex_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            v_in_reg      <= v_in_next;
            v_ex_reg      <= v_ex_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
    end

    ostt_slot_bank #(
        .SLOTS       (SLOTS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_bank (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .item       (req_reg),
        .expire_reg (expire),
        .hit_reg    (hit)
    );

    ostt_result #(
        .SLOTS (SLOTS)
    ) u_result (
        .clk    (clk),
        .adv    (adv),
        .expire (expire),
        .hit    (hit),
        .rsp    (rsp)
    );

    assign rsp_valid = rsp_valid_reg;

endmodule

// File: rtl/core/ostt_slot_bank.sv
// Slot state of the timer bank with per-slot tick, set and unset logic and the execute register.
module ostt_slot_bank #(
    parameter int SLOTS       = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ostt_pkg::exec_ctrl_t ctrl,
    input  ostt_pkg::req_t       item,
    output logic [SLOTS-1:0]     expire_reg,
    output logic                 hit_reg
);

    localparam int TW  = (COUNT_WIDTH > ostt_pkg::TICKS_W) ? COUNT_WIDTH : ostt_pkg::TICKS_W;
    localparam int IDW = ostt_pkg::ID_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [TW-1:0]          ticks_ext;
    logic [COUNT_WIDTH-1:0] target_load;
    logic                   do_tick;
    logic                   do_set;
    logic                   do_unset;
    logic [SLOTS-1:0]       expire_next;
    logic [SLOTS-1:0]       hit_vec;

    assign ticks_ext   = TW'(item.ticks);
    assign target_load = (ticks_ext > TW'(CNT_MAX)) ? CNT_MAX : ticks_ext[COUNT_WIDTH-1:0];

    assign do_tick  = ctrl.fire && (item.cmd == ostt_pkg::CMD_TICK);
    assign do_set   = ctrl.fire && (item.cmd == ostt_pkg::CMD_SET);
    assign do_unset = ctrl.fire && (item.cmd == ostt_pkg::CMD_UNSET);

    for (genvar g = 0; g < SLOTS; g++) begin : g_slot
        logic                   sel;
        logic                   armed_reg;
        logic                   armed_next;
        logic [COUNT_WIDTH-1:0] elapsed_reg;
        logic [COUNT_WIDTH-1:0] elapsed_next;
        logic [COUNT_WIDTH-1:0] target_reg;
        logic [COUNT_WIDTH-1:0] target_next;
        logic [COUNT_WIDTH-1:0] inc;
        logic                   exp_bit;
        logic                   hit_bit;

        // Only the first slots can be addressed by the four-bit slot field.
        assign sel = (g < ostt_pkg::ID_SLOTS) && (item.timer_id == IDW'(g));
        assign inc = (elapsed_reg == CNT_MAX) ? elapsed_reg
                                              : elapsed_reg + COUNT_WIDTH'(1);

        always_comb
        begin
            armed_next   = armed_reg;
            elapsed_next = elapsed_reg;
            target_next  = target_reg;
            exp_bit      = 1'b0;
            hit_bit      = 1'b0;
            if (do_tick && armed_reg)
            begin
                elapsed_next = inc;
                if (inc >= target_reg)
                begin
                    armed_next = 1'b0;
                    exp_bit    = 1'b1;
                end
            end
            if (do_set && sel)
            begin
                elapsed_next = '0;
                target_next  = target_load;
                armed_next   = 1'b1;
            end
            if (do_unset && sel)
            begin
                hit_bit    = armed_reg;
                armed_next = 1'b0;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                armed_reg   <= 1'b0;
                elapsed_reg <= '0;
                target_reg  <= '0;
            end
            else
            begin
                armed_reg   <= armed_next;
                elapsed_reg <= elapsed_next;
                target_reg  <= target_next;
            end
        end

        assign expire_next[g] = exp_bit;
        assign hit_vec[g]     = hit_bit;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv)
        begin
            expire_reg <= expire_next;
            hit_reg    <= |hit_vec;
        end
    end

endmodule

// File: rtl/core/ostt_result.sv
// Result stage of the timer bank: counts expired slots and registers the result item.
module ostt_result #(
    parameter int SLOTS = 16
) (
    input  logic               clk,
    input  logic               adv,
    input  logic [SLOTS-1:0]   expire,
    input  logic               hit,
    output ostt_pkg::rsp_t     rsp
);

    localparam int PW = $clog2(SLOTS + 1);
    localparam int SW = (PW > ostt_pkg::CNT_OUT_W) ? PW : ostt_pkg::CNT_OUT_W;
    localparam int MW = (SLOTS > ostt_pkg::MASK_W) ? SLOTS : ostt_pkg::MASK_W;

    logic [SW-1:0]   sum;
    logic [MW-1:0]   exp_wide;
    ostt_pkg::rsp_t  rsp_reg;
    ostt_pkg::rsp_t  rsp_next;

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            sum = sum + SW'(expire[i]);
        end
    end

    assign exp_wide = MW'(expire);

    // A tick never sets hit and an unset never expires a slot, so the two can be merged.
    always_comb
    begin
        rsp_next.count        = sum[ostt_pkg::CNT_OUT_W-1:0] | ostt_pkg::CNT_OUT_W'(hit);
        rsp_next.expired_mask = exp_wide[ostt_pkg::MASK_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

// File: rtl/core/ostt_checker.sv
// Port-level checker for the timer bank and the bind that attaches it to the top level.
`include "one_shot_tick_timer_bank_unit_macros.svh"

module ostt_checker #(
    parameter int SLOTS = 16
) (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input ostt_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input ostt_pkg::rsp_t rsp
);

    // A held result item must stay on the port unchanged.
    `OSTT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled result item changed")

    // The input side may only stall when a result item is waiting on a stalled output.
    `OSTT_ASSERT_IMPL(a_stall_cause, req_stall, rsp_valid && rsp_stall, "input stalled without output backpressure")

    // With every slot visible in the mask and some slot expired, the expiry count must match the mask.
    `OSTT_ASSERT_IMPL(a_count_mask, rsp_valid && (SLOTS <= 16) && (rsp.expired_mask != 16'd0), rsp.count == 5'($countones(rsp.expired_mask)), "expiry count differs from mask")

    // Mask bits above the last slot never light up.
    `OSTT_ASSERT_IMPL(a_mask_range, rsp_valid && (SLOTS < 16), (32'(rsp.expired_mask) >> SLOTS) == 32'd0, "mask bit set for a missing slot")

endmodule

bind one_shot_tick_timer_bank_unit ostt_checker #(.SLOTS(SLOTS)) u_ostt_checker (.*);
